[rtl/eic_pkg.sv]
// ----------------------------------------------------------------------------
// eic_pkg: shared types and constants of the Ethernet/IPv4 ingress classifier
// Holds the verdict codes, the frame offsets of the captured header fields
// and the record of captured header fields.
// ----------------------------------------------------------------------------
package eic_pkg;

	localparam int LENGTH_BITS_DEFAULT = 16;

	// frame layout (byte offsets from the destination MAC)
	localparam int POS_SRC_MAC_FIRST = 6;
	localparam int POS_SRC_MAC_LAST  = 11;
	localparam int POS_TYPE_FIRST    = 12;
	localparam int POS_TYPE_LAST     = 13;
	localparam int POS_IHL           = 14;
	localparam int POS_TOTAL_FIRST   = 16;
	localparam int POS_TOTAL_LAST    = 17;
	localparam int POS_PROTOCOL      = 23;
	localparam int POS_SRC_IP_FIRST  = 26;
	localparam int POS_SRC_IP_LAST   = 29;
	localparam int POS_DST_IP_FIRST  = 30;
	localparam int POS_DST_IP_LAST   = 33;

	localparam logic [3:0]  IHL_MASK        = 4'hF;
	localparam logic [16:0] MAC_HDR_BYTES   = 17'd14;
	localparam logic [5:0]  IPV4_MIN_HDR    = 6'd20;
	localparam logic [16:0] ARP_FRAME_MIN   = 17'd42;
	localparam logic [16:0] IPV4_FRAME_MIN  = 17'd34;
	localparam logic [15:0] ETHERTYPE_ARP   = 16'h0806;
	localparam logic [15:0] ETHERTYPE_IPV4  = 16'h0800;
	localparam logic [7:0]  PROTO_ICMP      = 8'd1;
	localparam logic [7:0]  PROTO_TCP       = 8'd6;
	localparam logic [7:0]  PROTO_UDP       = 8'd17;

	typedef enum logic [3:0] {
		VERDICT_RUNT      = 4'd0,
		VERDICT_ARP       = 4'd1,
		VERDICT_ARP_SHORT = 4'd2,
		VERDICT_NOT_IPV4  = 4'd3,
		VERDICT_BAD_IHL   = 4'd4,
		VERDICT_BAD_TOTAL = 4'd5,
		VERDICT_NOT_LOCAL = 4'd6,
		VERDICT_ICMP      = 4'd7,
		VERDICT_UDP       = 4'd8,
		VERDICT_TCP       = 4'd9,
		VERDICT_OTHER     = 4'd10
	} verdict_t;

	typedef struct packed {
		logic [15:0] ethertype;
		logic [47:0] src_mac;
		logic [3:0]  ihl;
		logic [15:0] total_length;
		logic [7:0]  protocol;
		logic [31:0] src_ip;
		logic [31:0] dst_ip;
	} hdr_fields_t;

endpackage

[rtl/eic_hdr_capture.sv]
// ----------------------------------------------------------------------------
// eic_hdr_capture: byte position counter and header field capture
// Counts frame bytes (saturating) and shifts the header bytes into their
// holding registers. Presents the fields and length as they stand after the
// current byte, so the final byte is classified in the same cycle.
// ----------------------------------------------------------------------------
module eic_hdr_capture #(
	parameter int LENGTH_BITS = eic_pkg::LENGTH_BITS_DEFAULT
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     step,
	input  logic [7:0]               byte_in,
	input  logic                     last,
	output eic_pkg::hdr_fields_t     fields_nx,
	output logic [LENGTH_BITS-1:0]   len_nx
);

	localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

	logic [LENGTH_BITS-1:0] pos_q;
	eic_pkg::hdr_fields_t   fields_q;

	function automatic logic in_span(input logic [LENGTH_BITS-1:0] p, input int lo,
			input int hi);
		in_span = (p >= LENGTH_BITS'(lo)) && (p <= LENGTH_BITS'(hi));
	endfunction

	always_comb begin
		fields_nx = fields_q;
		if (in_span(pos_q, eic_pkg::POS_SRC_MAC_FIRST, eic_pkg::POS_SRC_MAC_LAST)) begin
			fields_nx.src_mac = {fields_q.src_mac[39:0], byte_in};
		end
		if (in_span(pos_q, eic_pkg::POS_TYPE_FIRST, eic_pkg::POS_TYPE_LAST)) begin
			fields_nx.ethertype = {fields_q.ethertype[7:0], byte_in};
		end
		if (pos_q == LENGTH_BITS'(eic_pkg::POS_IHL)) begin
			fields_nx.ihl = byte_in[3:0] & eic_pkg::IHL_MASK;
		end
		if (in_span(pos_q, eic_pkg::POS_TOTAL_FIRST, eic_pkg::POS_TOTAL_LAST)) begin
			fields_nx.total_length = {fields_q.total_length[7:0], byte_in};
		end
		if (pos_q == LENGTH_BITS'(eic_pkg::POS_PROTOCOL)) begin
			fields_nx.protocol = byte_in;
		end
		if (in_span(pos_q, eic_pkg::POS_SRC_IP_FIRST, eic_pkg::POS_SRC_IP_LAST)) begin
			fields_nx.src_ip = {fields_q.src_ip[23:0], byte_in};
		end
		if (in_span(pos_q, eic_pkg::POS_DST_IP_FIRST, eic_pkg::POS_DST_IP_LAST)) begin
			fields_nx.dst_ip = {fields_q.dst_ip[23:0], byte_in};
		end
		len_nx = (pos_q != LEN_MAX) ? pos_q + 1'b1 : pos_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			fields_q <= '0;
		end else if (step) begin
			if (last) begin
				pos_q    <= '0;
				fields_q <= '0;
			end else begin
				pos_q    <= len_nx;
				fields_q <= fields_nx;
			end
		end
	end

endmodule

[rtl/eth_ipv4_ingress_classifier_top.sv]
// ----------------------------------------------------------------------------
// eth_ipv4_ingress_classifier_top: Ethernet/IPv4 ingress frame classifier
// Parses a byte-wide Ethernet frame and issues one verdict per frame.
// ----------------------------------------------------------------------------
// Frame bytes come in on a valid/ready request channel, one byte per request,
// with end_of_frame on the last byte. Every byte is taken into an input
// register; as it moves on it updates the saturating byte counter and the
// header holding registers, and on the last byte the verdict is formed in
// the same cycle and loaded into the result register. One byte is accepted
// every cycle while in_ready is high; a frame's result is loaded as its last
// byte leaves the input register. Only an unread result while another frame
// ends holds off input (in_ready then follows out_ready). The user must write
// local_ipv4_address via cfg_we only when no frame is in flight (unenforced).
// ----------------------------------------------------------------------------
module eth_ipv4_ingress_classifier_top #(
	parameter int LENGTH_BITS = eic_pkg::LENGTH_BITS_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_we,
	input  logic [31:0] local_ipv4_address,
	// frame bytes
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  frame_byte,
	input  logic        end_of_frame,
	// verdicts
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  verdict,
	output logic [31:0] sender_ipv4,
	output logic [47:0] sender_mac,
	output logic [6:0]  payload_offset,
	output logic [15:0] payload_length
);

	logic [31:0] local_ip_q;

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       adv_s1;

	// capture outputs
	eic_pkg::hdr_fields_t   fields_nx;
	logic [LENGTH_BITS-1:0] len_nx;

	// classification
	eic_pkg::verdict_t verdict_d;
	logic [31:0]       ip_d;
	logic [47:0]       mac_d;
	logic [6:0]        off_d;
	logic [15:0]       plen_d;
	logic [5:0]        hdr_len;
	logic [16:0]       len_w;
	logic [16:0]       total_w;

	// result register
	logic              out_valid_q;
	eic_pkg::verdict_t verdict_q;
	logic [31:0]       ip_q;
	logic [47:0]       mac_q;
	logic [6:0]        off_q;
	logic [15:0]       plen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_ip_q <= '0;
		end else if (cfg_we) begin
			local_ip_q <= local_ipv4_address;
		end
	end

	// a mid-frame byte always moves on; a last byte needs room for its result
	assign adv_s1   = valid_s1 && (!last_s1 || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= frame_byte;
			last_s1 <= end_of_frame;
		end
	end

	eic_hdr_capture #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_capture (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (adv_s1),
		.byte_in   (byte_s1),
		.last      (last_s1),
		.fields_nx (fields_nx),
		.len_nx    (len_nx)
	);

	// verdict chain, checked in order
	always_comb begin
		hdr_len   = {fields_nx.ihl, 2'b00};
		len_w     = 17'(len_nx);
		total_w   = 17'(fields_nx.total_length);
		verdict_d = eic_pkg::VERDICT_RUNT;
		ip_d      = '0;
		mac_d     = '0;
		off_d     = '0;
		plen_d    = '0;
		priority if (len_w < eic_pkg::MAC_HDR_BYTES) begin
			verdict_d = eic_pkg::VERDICT_RUNT;
		end else if (fields_nx.ethertype == eic_pkg::ETHERTYPE_ARP) begin
			verdict_d = (len_w >= eic_pkg::ARP_FRAME_MIN) ? eic_pkg::VERDICT_ARP
				: eic_pkg::VERDICT_ARP_SHORT;
		end else if (fields_nx.ethertype != eic_pkg::ETHERTYPE_IPV4
				|| len_w < eic_pkg::IPV4_FRAME_MIN) begin
			verdict_d = eic_pkg::VERDICT_NOT_IPV4;
		end else if (hdr_len < eic_pkg::IPV4_MIN_HDR
				|| len_w < eic_pkg::MAC_HDR_BYTES + 17'(hdr_len)) begin
			verdict_d = eic_pkg::VERDICT_BAD_IHL;
		end else begin
			off_d = 7'(eic_pkg::MAC_HDR_BYTES) + 7'(hdr_len);
			priority if (total_w < 17'(hdr_len)
					|| eic_pkg::MAC_HDR_BYTES + total_w > len_w) begin
				verdict_d = eic_pkg::VERDICT_BAD_TOTAL;
			end else if (fields_nx.dst_ip != local_ip_q) begin
				verdict_d = eic_pkg::VERDICT_NOT_LOCAL;
			end else begin
				priority if (fields_nx.protocol == eic_pkg::PROTO_ICMP) begin
					verdict_d = eic_pkg::VERDICT_ICMP;
				end else if (fields_nx.protocol == eic_pkg::PROTO_UDP) begin
					verdict_d = eic_pkg::VERDICT_UDP;
				end else if (fields_nx.protocol == eic_pkg::PROTO_TCP) begin
					verdict_d = eic_pkg::VERDICT_TCP;
				end else begin
					verdict_d = eic_pkg::VERDICT_OTHER;
				end
				ip_d   = fields_nx.src_ip;
				mac_d  = fields_nx.src_mac;
				plen_d = fields_nx.total_length - 16'(hdr_len);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && last_s1) begin
			verdict_q <= verdict_d;
			ip_q      <= ip_d;
			mac_q     <= mac_d;
			off_q     <= off_d;
			plen_q    <= plen_d;
		end
	end

	assign out_valid      = out_valid_q;
	assign verdict        = verdict_q;
	assign sender_ipv4    = ip_q;
	assign sender_mac     = mac_q;
	assign payload_offset = off_q;
	assign payload_length = plen_q;

endmodule

[bench/tb_eth_ipv4_ingress_classifier_top.sv]
// ----------------------------------------------------------------------------
// tb_eth_ipv4_ingress_classifier_top: frame classifier bench
// Drives Ethernet frames byte by byte with random source gaps and random
// sink stalls. A predictor tracks the captured header fields, queues one
// verdict per frame, and a sink process compares every field of every
// verdict in order. Directed frames cover each verdict, then random traffic
// runs across several host addresses.
// ----------------------------------------------------------------------------
module tb_eth_ipv4_ingress_classifier_top;

	// saturation point of the frame length counter
	localparam int LEN_MAX       = (1 << eic_pkg::LENGTH_BITS_DEFAULT) - 1;
	localparam int RANDOM_BYTES  = 240;
	localparam int RANDOM_FRAMES = 6;

	typedef struct packed {
		eic_pkg::verdict_t verdict;
		logic [31:0]       sender_ipv4;
		logic [47:0]       sender_mac;
		logic [6:0]        payload_offset;
		logic [15:0]       payload_length;
	} verdict_rec_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [31:0] local_ipv4_address;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  frame_byte;
	logic        end_of_frame;
	logic        out_valid;
	logic        out_ready;
	logic [3:0]  verdict;
	logic [31:0] sender_ipv4;
	logic [47:0] sender_mac;
	logic [6:0]  payload_offset;
	logic [15:0] payload_length;

	// predictor state: host address copy and the fields held for the open frame
	logic [31:0] host_ipv4;
	logic [15:0] frame_pos;
	logic [15:0] seen_ethertype;
	logic [47:0] seen_src_mac;
	logic [3:0]  seen_ihl;
	logic [15:0] seen_total;
	logic [7:0]  seen_protocol;
	logic [31:0] seen_src_ip;
	logic [31:0] seen_dst_ip;

	verdict_rec_t pending_verdicts[$];
	logic [7:0]   frame_buf[$];
	int           mismatches = 0;
	// steady modes switch off the per-request gaps on one side
	bit           tx_steady = 1'b0;
	bit           rx_steady = 1'b0;

	eth_ipv4_ingress_classifier_top u_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.local_ipv4_address(local_ipv4_address),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.frame_byte        (frame_byte),
		.end_of_frame      (end_of_frame),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.verdict           (verdict),
		.sender_ipv4       (sender_ipv4),
		.sender_mac        (sender_mac),
		.payload_offset    (payload_offset),
		.payload_length    (payload_length)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Predictor: one call per accepted byte. Captures header bytes at their
	// fixed offsets, bumps the saturating length and, on the last byte,
	// forms the verdict and clears the frame state.
	task automatic classify_byte(input logic [7:0] b, input logic last);
		int pos;
		int len;
		int hdr;
		int tot;
		verdict_rec_t r;
		pos = int'(frame_pos);
		if (pos >= eic_pkg::POS_SRC_MAC_FIRST && pos <= eic_pkg::POS_SRC_MAC_LAST)
			seen_src_mac = {seen_src_mac[39:0], b};
		else if (pos == eic_pkg::POS_TYPE_FIRST || pos == eic_pkg::POS_TYPE_LAST)
			seen_ethertype = {seen_ethertype[7:0], b};
		else if (pos == eic_pkg::POS_IHL)
			seen_ihl = b[3:0] & eic_pkg::IHL_MASK;   // version nibble ignored
		else if (pos == eic_pkg::POS_TOTAL_FIRST || pos == eic_pkg::POS_TOTAL_LAST)
			seen_total = {seen_total[7:0], b};
		else if (pos == eic_pkg::POS_PROTOCOL)
			seen_protocol = b;
		else if (pos >= eic_pkg::POS_SRC_IP_FIRST && pos <= eic_pkg::POS_SRC_IP_LAST)
			seen_src_ip = {seen_src_ip[23:0], b};
		else if (pos >= eic_pkg::POS_DST_IP_FIRST && pos <= eic_pkg::POS_DST_IP_LAST)
			seen_dst_ip = {seen_dst_ip[23:0], b};
		len = (pos < LEN_MAX) ? pos + 1 : LEN_MAX;
		frame_pos = 16'(len);
		if (!last)
			return;

		r = '0;
		hdr = int'(seen_ihl) * 4;
		tot = int'(seen_total);
		if (len < int'(eic_pkg::MAC_HDR_BYTES)) begin
			r.verdict = eic_pkg::VERDICT_RUNT;
		end else if (seen_ethertype == eic_pkg::ETHERTYPE_ARP) begin
			r.verdict = (len >= int'(eic_pkg::ARP_FRAME_MIN)) ? eic_pkg::VERDICT_ARP
				: eic_pkg::VERDICT_ARP_SHORT;
		end else if (seen_ethertype != eic_pkg::ETHERTYPE_IPV4
				|| len < int'(eic_pkg::IPV4_FRAME_MIN)) begin
			r.verdict = eic_pkg::VERDICT_NOT_IPV4;
		end else if (hdr < int'(eic_pkg::IPV4_MIN_HDR)
				|| len < int'(eic_pkg::MAC_HDR_BYTES) + hdr) begin
			r.verdict = eic_pkg::VERDICT_BAD_IHL;
		end else begin
			r.payload_offset = 7'(int'(eic_pkg::MAC_HDR_BYTES) + hdr);
			if (tot < hdr || int'(eic_pkg::MAC_HDR_BYTES) + tot > len) begin
				r.verdict = eic_pkg::VERDICT_BAD_TOTAL;
			end else if (seen_dst_ip != host_ipv4) begin
				r.verdict = eic_pkg::VERDICT_NOT_LOCAL;
			end else begin
				case (seen_protocol)
					eic_pkg::PROTO_ICMP: r.verdict = eic_pkg::VERDICT_ICMP;
					eic_pkg::PROTO_UDP:  r.verdict = eic_pkg::VERDICT_UDP;
					eic_pkg::PROTO_TCP:  r.verdict = eic_pkg::VERDICT_TCP;
					default:             r.verdict = eic_pkg::VERDICT_OTHER;
				endcase
				r.sender_ipv4    = seen_src_ip;
				r.sender_mac     = seen_src_mac;
				r.payload_length = 16'(tot - hdr);
			end
		end
		pending_verdicts.push_back(r);
		frame_pos      = '0;
		seen_ethertype = '0;
		seen_src_mac   = '0;
		seen_ihl       = '0;
		seen_total     = '0;
		seen_protocol  = '0;
		seen_src_ip    = '0;
		seen_dst_ip    = '0;
	endtask

	// Sends one byte request. Entered and left at a falling edge; valid is
	// only dropped when a gap is drawn, so back-to-back requests keep it high.
	task automatic send_frame_byte(input logic [7:0] b, input logic last);
		int gap;
		gap = tx_steady ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid     <= 1'b1;
		frame_byte   <= b;
		end_of_frame <= last;
		do @(posedge clk); while (!in_ready);
		classify_byte(b, last);
		@(negedge clk);
	endtask

	task automatic send_frame();
		for (int i = 0; i < frame_buf.size(); i++)
			send_frame_byte(frame_buf[i], i == frame_buf.size() - 1);
	endtask

	// Fills frame_buf with random bytes and lays the given header fields over
	// their offsets, as far as the frame reaches.
	task automatic build_frame(input int flen, input logic [15:0] etype,
			input logic [7:0] ver_ihl, input logic [15:0] total, input logic [7:0] proto,
			input logic [31:0] sip, input logic [31:0] dip, input logic [47:0] smac);
		logic [7:0] b;
		frame_buf.delete();
		for (int i = 0; i < flen; i++) begin
			b = 8'($urandom);
			if (i >= eic_pkg::POS_SRC_MAC_FIRST && i <= eic_pkg::POS_SRC_MAC_LAST)
				b = smac[8 * (eic_pkg::POS_SRC_MAC_LAST - i) +: 8];
			else if (i == eic_pkg::POS_TYPE_FIRST)
				b = etype[15:8];
			else if (i == eic_pkg::POS_TYPE_LAST)
				b = etype[7:0];
			else if (i == eic_pkg::POS_IHL)
				b = ver_ihl;
			else if (i == eic_pkg::POS_TOTAL_FIRST)
				b = total[15:8];
			else if (i == eic_pkg::POS_TOTAL_LAST)
				b = total[7:0];
			else if (i == eic_pkg::POS_PROTOCOL)
				b = proto;
			else if (i >= eic_pkg::POS_SRC_IP_FIRST && i <= eic_pkg::POS_SRC_IP_LAST)
				b = sip[8 * (eic_pkg::POS_SRC_IP_LAST - i) +: 8];
			else if (i >= eic_pkg::POS_DST_IP_FIRST && i <= eic_pkg::POS_DST_IP_LAST)
				b = dip[8 * (eic_pkg::POS_DST_IP_LAST - i) +: 8];
			frame_buf.push_back(b);
		end
	endtask

	// Drop valid, wait for every verdict, then allow for the two-stage
	// pipeline before touching configuration or ending the run.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_host_address(input logic [31:0] addr);
		wait_idle();
		cfg_we             <= 1'b1;
		local_ipv4_address <= addr;
		host_ipv4           = addr;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// ------------------------------------------------------------------
	// directed tests
	// ------------------------------------------------------------------

	// host address still at its reset value of zero
	task automatic test_default_host();
		build_frame(50, eic_pkg::ETHERTYPE_IPV4, 8'h45, 16'd36, eic_pkg::PROTO_UDP,
			32'hC0A8_0001, 32'h0, 48'h0200_0000_0001);
		send_frame();
	endtask

	// below 14 bytes, and 14 bytes that look like IPv4
	task automatic test_runt_frames();
		build_frame(1, eic_pkg::ETHERTYPE_IPV4, 8'h45, 16'd20, eic_pkg::PROTO_TCP,
			'0, '0, '0);
		send_frame();
		build_frame(13, eic_pkg::ETHERTYPE_IPV4, 8'h45, 16'd20, eic_pkg::PROTO_TCP,
			'0, '0, '0);
		send_frame();
		build_frame(14, eic_pkg::ETHERTYPE_IPV4, 8'h45, 16'd20, eic_pkg::PROTO_TCP,
			'0, '0, '0);
		send_frame();
	endtask

	// ARP at one byte short of the minimum, at the minimum and padded
	task automatic test_arp_frames();
		build_frame(41, eic_pkg::ETHERTYPE_ARP, 8'h00, 16'h0, 8'h0, '1, '1, '1);
		send_frame();
		build_frame(42, eic_pkg::ETHERTYPE_ARP, 8'h00, 16'h0, 8'h0, '1, '1, '1);
		send_frame();
		build_frame(48, eic_pkg::ETHERTYPE_ARP, 8'h45, 16'd30, eic_pkg::PROTO_UDP,
			'0, host_ipv4, '0);
		send_frame();
	endtask

	// foreign EtherType, and IPv4 one byte shorter than a bare header
	task automatic test_non_ipv4();
		build_frame(40, 16'h86DD, 8'h45, 16'd26, eic_pkg::PROTO_TCP, '0, host_ipv4, '0);
		send_frame();
		build_frame(33, eic_pkg::ETHERTYPE_IPV4, 8'h45, 16'd19, eic_pkg::PROTO_TCP,
			'0, host_ipv4, '0);
		send_frame();
		build_frame(40, 16'hFFFF, 8'h45, 16'd20, eic_pkg::PROTO_TCP, '0, host_ipv4, '0);
		send_frame();
	endtask

	// IHL below five words, and a header cut off by the frame end
	task automatic test_header_length();
		build_frame(40, eic_pkg::ETHERTYPE_IPV4, 8'h40, 16'd26, eic_pkg::PROTO_UDP,
			'0, host_ipv4, '0);
		send_frame();
		build_frame(40, eic_pkg::ETHERTYPE_IPV4, 8'h44, 16'd26, eic_pkg::PROTO_UDP,
			'0, host_ipv4, '0);
		send_frame();
		build_frame(73, eic_pkg::ETHERTYPE_IPV4, 8'h4F, 16'd60, eic_pkg::PROTO_UDP,
			'0, host_ipv4, '0);
		send_frame();
		// largest header, no payload: offset at its top value
		build_frame(74, eic_pkg::ETHERTYPE_IPV4, 8'h4F, 16'd60, eic_pkg::PROTO_UDP,
			32'h0A00_0002, host_ipv4, 48'h0011_2233_4455);
		send_frame();
	endtask

	// total below the header, total past the frame end, and exactly filling it
	task automatic test_total_length();
		build_frame(40, eic_pkg::ETHERTYPE_IPV4, 8'h45, 16'd19, eic_pkg::PROTO_TCP,
			'0, host_ipv4, '0);
		send_frame();
		build_frame(40, eic_pkg::ETHERTYPE_IPV4, 8'h45, 16'd27, eic_pkg::PROTO_TCP,
			'0, host_ipv4, '0);
		send_frame();
		build_frame(40, eic_pkg::ETHERTYPE_IPV4, 8'h45, 16'hFFFF, eic_pkg::PROTO_TCP,
			'0, host_ipv4, '0);
		send_frame();
		build_frame(40, eic_pkg::ETHERTYPE_IPV4, 8'h46, 16'd26, eic_pkg::PROTO_TCP,
			32'h0102_0304, host_ipv4, 48'hA1B2_C3D4_E5F6);
		send_frame();
	endtask

	// each protocol branch; version nibble takes odd values on purpose
	task automatic test_protocols();
		build_frame(40, eic_pkg::ETHERTYPE_IPV4, 8'hF5, 16'd22, eic_pkg::PROTO_ICMP,
			32'h1, host_ipv4, 48'h1);
		send_frame();
		build_frame(40, eic_pkg::ETHERTYPE_IPV4, 8'h05, 16'd26, eic_pkg::PROTO_UDP,
			32'h2, host_ipv4, 48'h2);
		send_frame();
		build_frame(40, eic_pkg::ETHERTYPE_IPV4, 8'h65, 16'd20, eic_pkg::PROTO_TCP,
			32'h3, host_ipv4, 48'h3);
		send_frame();
		build_frame(40, eic_pkg::ETHERTYPE_IPV4, 8'h45, 16'd24, 8'h00,
			32'h4, host_ipv4, 48'h4);
		send_frame();
		build_frame(40, eic_pkg::ETHERTYPE_IPV4, 8'h45, 16'd24, 8'hFF,
			32'h5, host_ipv4, 48'h5);
		send_frame();
	endtask

	// destination matching at both address extremes
	task automatic test_host_match();
		set_host_address(32'hFFFF_FFFF);
		build_frame(48, eic_pkg::ETHERTYPE_IPV4, 8'h45, 16'd30, eic_pkg::PROTO_UDP,
			'1, 32'hFFFF_FFFF, '1);
		send_frame();
		build_frame(48, eic_pkg::ETHERTYPE_IPV4, 8'h45, 16'd30, eic_pkg::PROTO_UDP,
			'1, 32'hFFFF_FFFE, '1);
		send_frame();
		set_host_address(32'h0);
		build_frame(48, eic_pkg::ETHERTYPE_IPV4, 8'h45, 16'd30, eic_pkg::PROTO_TCP,
			'0, 32'h0, '0);
		send_frame();
		build_frame(48, eic_pkg::ETHERTYPE_IPV4, 8'h45, 16'd30, eic_pkg::PROTO_TCP,
			'0, 32'h8000_0000, '0);
		send_frame();
	endtask

	// Random traffic: mostly well-formed IPv4 with random content, the rest
	// broken IPv4, ARP and noise. Host address and idle modes change every
	// two frames.
	task automatic test_random_traffic();
		int bytes_sent;
		int frames;
		int phase;
		int kind;
		int ihl;
		int tot;
		int flen;
		logic [7:0]  proto;
		logic [31:0] dip;
		logic [15:0] etype;
		bytes_sent = 0;
		frames     = 0;
		phase      = 0;
		while (bytes_sent < RANDOM_BYTES || frames < RANDOM_FRAMES) begin
			if (frames % 2 == 0) begin
				case (phase % 4)
					0:       set_host_address(32'h0);
					1:       set_host_address(32'hFFFF_FFFF);
					default: set_host_address($urandom);
				endcase
				phase++;
				tx_steady = ($urandom_range(0, 3) == 0);
				rx_steady = ($urandom_range(0, 3) == 0);
			end
			kind = $urandom_range(0, 9);
			case (kind)
				0, 1, 2, 3, 4, 5: begin
					// well-formed; the last of these goes to a random destination
					ihl  = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 15) : 5;
					tot  = ihl * 4 + $urandom_range(0, 8);
					flen = 14 + tot + $urandom_range(0, 3);
					dip  = (kind == 5) ? $urandom : host_ipv4;
					case ($urandom_range(0, 3))
						0:       proto = eic_pkg::PROTO_ICMP;
						1:       proto = eic_pkg::PROTO_UDP;
						2:       proto = eic_pkg::PROTO_TCP;
						default: proto = 8'($urandom);
					endcase
					build_frame(flen, eic_pkg::ETHERTYPE_IPV4, {4'($urandom), 4'(ihl)},
						16'(tot), proto, $urandom, dip, {16'($urandom), 32'($urandom)});
				end
				6: begin
					// any IHL and total against a random length
					build_frame($urandom_range(34, 90), eic_pkg::ETHERTYPE_IPV4,
						8'($urandom), 16'($urandom_range(0, 80)), 8'($urandom),
						$urandom, host_ipv4, {16'($urandom), 32'($urandom)});
				end
				7: begin
					build_frame($urandom_range(30, 64), eic_pkg::ETHERTYPE_ARP, 8'($urandom),
						16'($urandom), 8'($urandom), $urandom, $urandom,
						{16'($urandom), 32'($urandom)});
				end
				default: begin
					// noise, sometimes with a plausible EtherType
					case ($urandom_range(0, 2))
						0:       etype = eic_pkg::ETHERTYPE_IPV4;
						1:       etype = eic_pkg::ETHERTYPE_ARP;
						default: etype = 16'($urandom);
					endcase
					build_frame($urandom_range(1, 70), etype, 8'($urandom), 16'($urandom),
						8'($urandom), $urandom, $urandom, {16'($urandom), 32'($urandom)});
				end
			endcase
			send_frame();
			bytes_sent += frame_buf.size();
			frames++;
		end
	endtask

	// Sink: draws a stall before each verdict, then holds ready high until
	// one is taken, and checks it against the oldest pending expectation.
	initial begin : verdict_sink
		int hold;
		verdict_rec_t want;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			hold = rx_steady ? 0 : $urandom_range(0, 9);
			if (hold > 0) begin
				out_ready <= 1'b0;
				repeat (hold) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid === 1'b1 && out_ready));
			if (pending_verdicts.size() == 0) begin
				$error("verdict %0d with no frame pending", verdict);
				mismatches++;
			end else begin
				want = pending_verdicts.pop_front();
				if (verdict !== want.verdict) begin
					$error("verdict: expected %0d, got %0d", want.verdict, verdict);
					mismatches++;
				end
				if (sender_ipv4 !== want.sender_ipv4) begin
					$error("sender_ipv4: expected %h, got %h", want.sender_ipv4, sender_ipv4);
					mismatches++;
				end
				if (sender_mac !== want.sender_mac) begin
					$error("sender_mac: expected %h, got %h", want.sender_mac, sender_mac);
					mismatches++;
				end
				if (payload_offset !== want.payload_offset) begin
					$error("payload_offset: expected %0d, got %0d", want.payload_offset,
						payload_offset);
					mismatches++;
				end
				if (payload_length !== want.payload_length) begin
					$error("payload_length: expected %0d, got %0d", want.payload_length,
						payload_length);
					mismatches++;
				end
			end
			@(negedge clk);
		end
	end

	// Main sequence: reset once, directed tests, random traffic, drain.
	initial begin
		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		local_ipv4_address = '0;
		in_valid           = 1'b0;
		frame_byte         = '0;
		end_of_frame       = 1'b0;
		host_ipv4          = '0;
		frame_pos          = '0;
		seen_ethertype     = '0;
		seen_src_mac       = '0;
		seen_ihl           = '0;
		seen_total         = '0;
		seen_protocol      = '0;
		seen_src_ip        = '0;
		seen_dst_ip        = '0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_default_host();
		set_host_address(32'hC0A8_0A0A);
		test_runt_frames();
		test_arp_frames();
		test_non_ipv4();
		test_header_length();
		test_total_length();
		test_protocols();
		test_host_match();
		test_random_traffic();

		wait_idle();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#2000000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
